@@ src/apc_pkg.sv @@
// Shared types and constants for the animation playback clock.
package apc_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int POS_W        = FRAC_BITS + 1;
    localparam int FRAMES_W     = 12;
    localparam int SPEED_W      = 16;
    localparam int DT_W         = 20;
    localparam int ELAPSED_W    = 32;
    localparam int LEN_US_W     = 28;
    localparam int LEN_MS_W     = 18;
    localparam int EMS_W        = 23;
    localparam int MUL_A_W      = 30;
    localparam int MUL_B_W      = 29;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT  = 36;
    localparam int DIV_CNT_W    = $clog2(POS_W + 1);

    localparam logic [POS_W-1:0]   FIX_ONE      = POS_W'(1 << FRAC_BITS);
    localparam logic [MUL_B_W-1:0] US_PER_FRAME = MUL_B_W'(33333);
    localparam logic [MUL_A_W-1:0] RECIP_125    = MUL_A_W'(549755814);

    typedef enum logic [1:0] {
        CFG_SPEED,
        CFG_LOOPED,
        CFG_FRAMES,
        CFG_START
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_LEN,
        S_CHECK,
        S_LENMS,
        S_DIVLD,
        S_DIV,
        S_FRAME_A,
        S_FRAME_B,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [EMS_W-1:0]    num;
        logic [LEN_MS_W-1:0] den;
    } div_req_t;

endpackage

@@ src/apc_mul.sv @@
// Shared multiplier with registered product.
module apc_mul
    import apc_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ src/apc_div.sv @@
// Restoring divider for the normalized position, one quotient bit per cycle.
module apc_div
    import apc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [POS_W-1:0] quot
);

    logic [LEN_MS_W-1:0]  rem_reg, rem_next;
    logic [LEN_MS_W-1:0]  den_reg, den_next;
    logic [POS_W-1:0]     bits_reg, bits_next;
    logic [POS_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [LEN_MS_W:0]    trial;
    logic                 fits;
    logic                 saturate;

    assign trial    = {rem_reg, bits_reg[POS_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign saturate = (req.den == '0) || (req.num >= EMS_W'({req.den, 1'b0}));

    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        bits_next  = bits_reg;
        quot_next  = quot_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            den_next = req.den;
            if (saturate)
            begin
                quot_next = FIX_ONE;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next   = LEN_MS_W'(req.num >> 1);
                bits_next  = {req.num[0], {FRAC_BITS{1'b0}}};
                quot_next  = '0;
                count_next = DIV_CNT_W'(POS_W);
                run_next   = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = LEN_MS_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = LEN_MS_W'(trial);
            end
            quot_next  = {quot_reg[POS_W-2:0], fits};
            bits_next  = {bits_reg[POS_W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = (quot_reg > FIX_ONE) ? FIX_ONE : quot_reg;

    a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("divider reports done while still running");

endmodule

@@ src/animation_playback_clock.sv @@
// Top level: playback position clock with sequencer, shared multiplier and divider.
// A tick on a running clip runs scale, length, check, length in ms, divider load, divide and
// the two frame steps; a one-shot clip that ends goes from the check to the frame steps, and
// a start or a tick on an idle or ended clip goes straight to them. A stalled result holds
// the sequencer until it is taken. Requests are taken only in idle, so a new one waits for
// the last result. The position divider takes 13 steps; the shared multiplier serves up to
// six uses per request. Reset clears the clip state and output valid, and sets the defaults.
module animation_playback_clock
    import apc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // frame_dt_us[19:0], zero pad
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // position, frame_index, frame_changed, ended, active
);

    state_t state_reg, state_next;

    logic [SPEED_W-1:0]   speed_reg;
    logic                 looped_reg;
    logic [FRAMES_W-1:0]  frames_reg;
    logic [POS_W-1:0]     start_reg;

    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [POS_W-1:0]     pos_now_reg, pos_now_next;
    logic [POS_W-1:0]     pos_before_reg, pos_before_next;
    logic                 ended_reg, ended_next;
    logic                 active_reg, active_next;
    logic [DT_W-1:0]      dt_reg, dt_next;
    logic [LEN_MS_W-1:0]  len_ms_reg, len_ms_next;
    logic [POS_W-1:0]     frame_now_reg, frame_now_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_data_reg, m_data_next;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod;
    div_req_t             div_req;
    logic                 div_done;
    logic [POS_W-1:0]     div_quot;

    logic                 in_accept;
    logic                 negative;
    logic                 speed_pos;
    logic [SPEED_W-1:0]   speed_mag;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [LEN_US_W-1:0]  len_us;
    logic                 exceeded;
    logic                 can_load;
    logic [POS_W-1:0]     start_pos;
    logic [POS_W-1:0]     frame_before;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign negative     = speed_reg[SPEED_W-1];
    assign speed_pos    = !negative && (speed_reg != '0);
    assign speed_mag    = negative ? SPEED_W'(-speed_reg) : speed_reg;
    assign elapsed_sum  = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(prod[PROD_W-1:FRAC_BITS]);
    assign len_us       = prod[LEN_US_W-1:0];
    assign exceeded     = elapsed_reg > ELAPSED_W'(len_us);
    assign can_load     = !m_valid_reg || m_axis_tready;
    assign frame_before = prod[FRAC_BITS +: POS_W];

    always_comb
    begin
        if (start_reg != '0)
        begin
            start_pos = (start_reg > FIX_ONE) ? FIX_ONE : start_reg;
        end
        else
        begin
            start_pos = speed_pos ? '0 : FIX_ONE;
        end
    end

    apc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    apc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_W'(FIX_ONE);
            looped_reg <= 1'b0;
            frames_reg <= FRAMES_W'(30);
            start_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SPEED:  speed_reg  <= cfg_data;
                CFG_LOOPED: looped_reg <= cfg_data[0];
                CFG_FRAMES: frames_reg <= cfg_data[FRAMES_W-1:0];
                CFG_START:  start_reg  <= cfg_data[POS_W-1:0];
                default:    speed_reg  <= speed_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (!s_axis_tuser && active_reg && !ended_reg)
                    begin
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        state_next = S_FRAME_A;
                    end
                end
            end
            S_SCALE:   state_next = S_LEN;
            S_LEN:     state_next = S_CHECK;
            S_CHECK:   state_next = (!looped_reg && exceeded) ? S_FRAME_A : S_LENMS;
            S_LENMS:   state_next = S_DIVLD;
            S_DIVLD:   state_next = S_DIV;
            S_DIV:     state_next = div_done ? S_FRAME_A : S_DIV;
            S_FRAME_A: state_next = S_FRAME_B;
            S_FRAME_B: state_next = S_OUT;
            S_OUT:     state_next = can_load ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        elapsed_next    = elapsed_reg;
        pos_now_next    = pos_now_reg;
        pos_before_next = pos_before_reg;
        ended_next      = ended_reg;
        active_next     = active_reg;
        dt_next         = dt_reg;
        len_ms_next     = len_ms_reg;
        frame_now_next  = frame_now_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        mul_a           = MUL_A_W'(pos_before_reg);
        mul_b           = MUL_B_W'(frames_reg);
        div_req.start   = 1'b0;
        div_req.num     = prod[RECIP_SHIFT +: EMS_W];
        div_req.den     = len_ms_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    dt_next = s_axis_tdata[DT_W-1:0];
                    if (s_axis_tuser)
                    begin
                        pos_now_next    = start_pos;
                        pos_before_next = start_pos;
                        elapsed_next    = '0;
                        ended_next      = 1'b0;
                        active_next     = 1'b1;
                    end
                end
            end
            S_SCALE:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = MUL_B_W'(speed_mag);
            end
            S_LEN:
            begin
                elapsed_next = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
                mul_a        = MUL_A_W'(frames_reg);
                mul_b        = US_PER_FRAME;
            end
            S_CHECK:
            begin
                pos_before_next = pos_now_reg;
                mul_a           = RECIP_125;
                mul_b           = MUL_B_W'(len_us >> 3);
                if (exceeded)
                begin
                    if (!looped_reg)
                    begin
                        pos_now_next = negative ? '0 : FIX_ONE;
                        ended_next   = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg - ELAPSED_W'(len_us);
                    end
                end
            end
            S_LENMS:
            begin
                len_ms_next = prod[RECIP_SHIFT +: LEN_MS_W];
                mul_a       = RECIP_125;
                mul_b       = elapsed_reg[ELAPSED_W-1:3];
            end
            S_DIVLD:
            begin
                div_req.start = 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pos_now_next = negative ? FIX_ONE - div_quot : div_quot;
                end
            end
            S_FRAME_A:
            begin
                mul_a = MUL_A_W'(pos_now_reg);
                mul_b = MUL_B_W'(frames_reg);
            end
            S_FRAME_B:
            begin
                frame_now_next = prod[FRAC_BITS +: POS_W];
            end
            S_OUT:
            begin
                if (can_load)
                begin
                    m_valid_next = 1'b1;
                    if (active_reg)
                    begin
                        m_data_next = {4'b0, active_reg, ended_reg,
                                       frame_before != frame_now_reg,
                                       frame_now_reg[FRAMES_W-1:0], pos_now_reg};
                    end
                    else
                    begin
                        m_data_next = '0;
                    end
                end
            end
            default:
            begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            elapsed_reg    <= '0;
            pos_now_reg    <= '0;
            pos_before_reg <= '0;
            ended_reg      <= 1'b0;
            active_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            pos_now_reg    <= pos_now_next;
            pos_before_reg <= pos_before_next;
            ended_reg      <= ended_next;
            active_reg     <= active_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        len_ms_reg    <= len_ms_next;
        frame_now_reg <= frame_now_next;
        m_data_reg    <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_ended_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> active_reg)
        else $error("clip ended without being started");

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_now_reg <= FIX_ONE && pos_before_reg <= FIX_ONE)
        else $error("position beyond one");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

endmodule

@@ tb/tb_animation_playback_clock.sv @@
// Self-checking testbench for the animation playback clock: random stream traffic vs. a predictor.
module tb_animation_playback_clock
    import apc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int                 RESET_CYCLES = 9;
    localparam int                 SETTLE       = 40;
    localparam int                 LONG_HOLD    = 400;
    localparam int                 STALL_LIMIT  = 5000;
    localparam int                 RANDOM_ITEMS = 1950;
    localparam longint unsigned    FRAME_US     = 33333;
    localparam longint unsigned    ONE          = 1 << FRAC_BITS;
    localparam logic [DT_W-1:0]    DT_MAX       = '1;

    typedef struct {
        logic            op;
        logic [DT_W-1:0] dt;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [FRAMES_W-1:0] frame_index;
        logic                changed;
        logic                ended;
        logic                active;
    } playback_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // frame_dt_us[19:0], zero pad
    logic        s_axis_tuser  = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // position, frame_index, frame_changed, ended, active

    animation_playback_clock uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // Register mirror and clip state of the predictor.
    logic signed [SPEED_W-1:0] speed_reg;
    logic                      looped_reg;
    logic [FRAMES_W-1:0]       frames_reg;
    logic [POS_W-1:0]          start_reg;
    logic [ELAPSED_W-1:0]      elapsed_us;
    logic [POS_W-1:0]          pos_now;
    logic [POS_W-1:0]          pos_prev;
    logic                      clip_ended;
    logic                      clip_active;

    request_t  pending_requests[$];
    playback_t expected_playback[$];
    int        mismatches      = 0;
    int        long_hold_asks  = 0;
    int        long_hold_done  = 0;

    function automatic longint unsigned frame_at(logic [POS_W-1:0] pos);
        return (longint'(pos) * longint'(frames_reg)) >> FRAC_BITS;
    endfunction

    task automatic advance_clock(request_t r);
        longint unsigned len_us;
        longint unsigned len_ms;
        longint unsigned mag;
        longint unsigned sum;
        longint unsigned q;
        logic            negative;
        playback_t       res;
        len_us   = longint'(frames_reg) * FRAME_US;
        len_ms   = len_us / 1000;
        negative = speed_reg < 0;
        if (r.op == OP_START)
        begin
            if (start_reg != 0)
                pos_now = (start_reg > ONE) ? POS_W'(ONE) : start_reg;
            else
                pos_now = (speed_reg > 0) ? '0 : POS_W'(ONE);
            pos_prev    = pos_now;
            elapsed_us  = '0;
            clip_ended  = 1'b0;
            clip_active = 1'b1;
        end
        else if (clip_active && !clip_ended)
        begin
            mag = negative ? longint'(-longint'(speed_reg)) : longint'(speed_reg);
            sum = longint'(elapsed_us) + ((longint'(r.dt) * mag) >> FRAC_BITS);
            elapsed_us = (sum > 64'hFFFF_FFFF) ? '1 : ELAPSED_W'(sum);
            pos_prev   = pos_now;
            if (!looped_reg && longint'(elapsed_us) > len_us)
            begin
                pos_now    = negative ? '0 : POS_W'(ONE);
                clip_ended = 1'b1;
            end
            else
            begin
                if (longint'(elapsed_us) > len_us)
                    elapsed_us = ELAPSED_W'(longint'(elapsed_us) - len_us);
                if (len_ms == 0)
                begin
                    q = ONE;
                end
                else
                begin
                    q = ((longint'(elapsed_us) / 1000) << FRAC_BITS) / len_ms;
                    if (q > ONE)
                        q = ONE;
                end
                if (negative)
                    q = ONE - q;
                pos_now = POS_W'(q);
            end
        end
        res = '0;
        if (clip_active)
        begin
            res.position    = pos_now;
            res.frame_index = FRAMES_W'(frame_at(pos_now));
            res.changed     = frame_at(pos_prev) != frame_at(pos_now);
            res.ended       = clip_ended;
            res.active      = 1'b1;
        end
        expected_playback.push_back(res);
    endtask

    // Sender: bursts of requests with random gaps.
    request_t cur_req;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_clock(cur_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, cur_req.dt};
                    s_axis_tuser  <= cur_req.op;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern per segment, plus long hold-offs on request.
    int hold_left = 0;
    int seg_left  = 0;
    int rx_mode   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (long_hold_asks != long_hold_done)
        begin
            long_hold_done++;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 256);
                rx_mode  = $urandom_range(0, 3);
            end
            seg_left--;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (seg_left % 8) < 5;
            endcase
        end
    end

    playback_t got;
    playback_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.position    = m_axis_tdata[12:0];
            got.frame_index = m_axis_tdata[24:13];
            got.changed     = m_axis_tdata[25];
            got.ended       = m_axis_tdata[26];
            got.active      = m_axis_tdata[27];
            if (expected_playback.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result with no request pending: %h", $realtime, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_playback.pop_front();
                if (got != want)
                begin
                    if (mismatches < 10)
                        $display("%0t: pos %0d/%0d frame %0d/%0d chg %0b/%0b end %0b/%0b act %0b/%0b",
                                 $realtime, want.position, got.position,
                                 want.frame_index, got.frame_index, want.changed, got.changed,
                                 want.ended, got.ended, want.active, got.active);
                    mismatches++;
                end
            end
        end
    end

    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("animation_playback_clock: mismatch");
            $finish;
        end
    end

    task automatic push_req(logic op, logic [DT_W-1:0] dt);
        request_t r;
        r.op = op;
        r.dt = dt;
        pending_requests.push_back(r);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SPEED:  speed_reg  = val;
            CFG_LOOPED: looped_reg = val[0];
            CFG_FRAMES: frames_reg = val[FRAMES_W-1:0];
            default:    start_reg  = val[POS_W-1:0];
        endcase
    endtask

    task automatic set_playback(logic [15:0] speed, logic looped, logic [11:0] frames,
                                logic [12:0] start);
        write_reg(CFG_SPEED, speed);
        write_reg(CFG_LOOPED, 16'(looped));
        write_reg(CFG_FRAMES, 16'(frames));
        write_reg(CFG_START, 16'(start));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_playback.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Start a clip, then tick it with frame times sized to cross it in about the given number of ticks.
    task automatic queue_clip(int ticks);
        longint unsigned len_us;
        longint unsigned mag;
        longint unsigned span;
        int              sel;
        push_req(OP_START, DT_W'($urandom));
        len_us = longint'(frames_reg) * FRAME_US;
        mag    = (speed_reg < 0) ? longint'(-longint'(speed_reg)) : longint'(speed_reg);
        if (mag == 0)
            mag = ONE;
        span = (2 * len_us * ONE) / (mag * longint'(ticks));
        if (span > DT_MAX)
            span = DT_MAX;
        if (span == 0)
            span = 1;
        repeat (ticks)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                push_req(OP_TICK, '0);
            else if (sel == 1)
                push_req(OP_TICK, DT_MAX);
            else if (sel == 2)
                push_req(OP_TICK, DT_W'($urandom));
            else
                push_req(OP_TICK, DT_W'($urandom_range(0, int'(span))));
        end
    endtask

    task automatic random_playback();
        logic [15:0] speed;
        logic [11:0] frames;
        logic [12:0] start;
        case ($urandom_range(0, 9))
            0:       speed = 16'h8000;
            1:       speed = 16'h7FFF;
            2:       speed = '0;
            3:       speed = 16'($urandom);
            4, 5, 6: speed = 16'($urandom_range(512, 16384));
            default: speed = -16'($urandom_range(512, 16384));
        endcase
        case ($urandom_range(0, 15))
            0:       frames = 12'd4095;
            1:       frames = '0;
            2:       frames = 12'd1;
            3:       frames = 12'($urandom);
            default: frames = 12'($urandom_range(2, 60));
        endcase
        case ($urandom_range(0, 9))
            0:          start = 13'($urandom);
            1, 2, 3, 4: start = 13'($urandom_range(0, 4096));
            default:    start = '0;
        endcase
        set_playback(speed, 1'($urandom), frames, start);
    endtask

    int queued = 0;
    int phase_items;
    int phase_no = 0;

    initial
    begin
        speed_reg   = 16'sd4096;
        looped_reg  = 1'b0;
        frames_reg  = 12'd30;
        start_reg   = '0;
        elapsed_us  = '0;
        pos_now     = '0;
        pos_prev    = '0;
        clip_ended  = 1'b0;
        clip_active = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Default settings: ticks before any start, then one-shot to the end.
        push_req(OP_TICK, '0);
        push_req(OP_TICK, DT_MAX);
        push_req(OP_START, DT_MAX);
        push_req(OP_TICK, '0);
        push_req(OP_TICK, 20'd33333);
        push_req(OP_TICK, DT_MAX);
        push_req(OP_TICK, 20'd1000);
        push_req(OP_START, '0);
        push_req(OP_TICK, 20'd500000);
        push_req(OP_TICK, 20'd499990);
        push_req(OP_TICK, 20'd1);
        wait_drained();

        // Fastest reverse, looped, one-frame clip, start point above one.
        set_playback(16'h8000, 1'b1, 12'd1, 13'h1FFF);
        push_req(OP_START, '0);
        push_req(OP_TICK, DT_MAX);
        push_req(OP_TICK, 20'd1);
        push_req(OP_TICK, '0);
        wait_drained();

        // Zero clip length with zero speed.
        set_playback(16'h0000, 1'b0, 12'd0, 13'd0);
        push_req(OP_START, '0);
        push_req(OP_TICK, 20'd1000);
        push_req(OP_TICK, DT_MAX);
        wait_drained();

        // Fastest forward on the longest clip from a start point of one.
        set_playback(16'h7FFF, 1'b0, 12'd4095, 13'd4096);
        push_req(OP_START, '0);
        push_req(OP_TICK, DT_MAX);
        push_req(OP_TICK, DT_MAX);
        wait_drained();

        while (queued < RANDOM_ITEMS)
        begin
            random_playback();
            phase_no++;
            if (phase_no == 2 || phase_no == 20)
                long_hold_asks++;
            phase_items = $urandom_range(30, 90);
            while (phase_items > 0)
            begin
                int ticks;
                ticks = $urandom_range(3, 40);
                queue_clip(ticks);
                phase_items -= ticks + 1;
                queued      += ticks + 1;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("animation_playback_clock: match");
        else
            $display("animation_playback_clock: mismatch");
        $finish;
    end

endmodule
